@@ hw/rtl/ccpv_pkg.sv @@
// ----------------------------------------------------------------------------
// ccpv_pkg: shared constants for the center crop or pad volume block
// Register indexes and the fixed widths of the configuration port and of the
// destination address.
// ----------------------------------------------------------------------------
`default_nettype none

package ccpv_pkg;

	// Fixed widths of the configuration registers and of the port.
	localparam int SIZE_REG_W = 13;
	localparam int CHAN_REG_W = 5;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 3;

	// Width of the linear destination address.
	localparam int ADDR_W = 40;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SRC_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_Z    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DST_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DST_Z    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd6;

endpackage

`default_nettype wire

@@ hw/rtl/ccpv_cfg.sv @@
// ----------------------------------------------------------------------------
// ccpv_cfg: configuration registers
// Holds the volume sizes and the channel count, clamped into their legal
// ranges as they are written.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpv_cfg #(
	parameter int MAX_DIM      = 4096,
	parameter int MAX_CHANNELS = 16,
	parameter int DIM_W        = 13,
	parameter int CHN_W        = 5
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [ccpv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ccpv_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic      [DIM_W-1:0]               src_x,
	output logic      [DIM_W-1:0]               src_y,
	output logic      [DIM_W-1:0]               src_z,
	output logic      [DIM_W-1:0]               dst_x,
	output logic      [DIM_W-1:0]               dst_y,
	output logic      [DIM_W-1:0]               dst_z,
	output logic      [CHN_W-1:0]               chan_count
);
	import ccpv_pkg::*;

	logic [SIZE_REG_W-1:0] dim_raw;
	logic [CHAN_REG_W-1:0] chan_raw;
	logic [DIM_W-1:0]      dim_clamp;
	logic [CHN_W-1:0]      chan_clamp;
	logic [DIM_W-1:0]      src_x_q, src_y_q, src_z_q;
	logic [DIM_W-1:0]      dst_x_q, dst_y_q, dst_z_q;
	logic [CHN_W-1:0]      chan_q;

	// A size of zero acts as one; anything above the maximum acts as the maximum.
	always_comb begin
		dim_raw  = cfg_data[SIZE_REG_W-1:0];
		chan_raw = cfg_data[CHAN_REG_W-1:0];
		if (dim_raw == '0) begin
			dim_clamp = DIM_W'(1);
		end else if (32'(dim_raw) > 32'(MAX_DIM)) begin
			dim_clamp = DIM_W'(MAX_DIM);
		end else begin
			dim_clamp = DIM_W'(dim_raw);
		end
		if (chan_raw == '0) begin
			chan_clamp = CHN_W'(1);
		end else if (32'(chan_raw) > 32'(MAX_CHANNELS)) begin
			chan_clamp = CHN_W'(MAX_CHANNELS);
		end else begin
			chan_clamp = CHN_W'(chan_raw);
		end
	end

	// Register file; an index beyond the list writes nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_x_q <= DIM_W'(1);
			src_y_q <= DIM_W'(1);
			src_z_q <= DIM_W'(1);
			dst_x_q <= DIM_W'(1);
			dst_y_q <= DIM_W'(1);
			dst_z_q <= DIM_W'(1);
			chan_q  <= CHN_W'(1);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SRC_X:    src_x_q <= dim_clamp;
				REG_SRC_Y:    src_y_q <= dim_clamp;
				REG_SRC_Z:    src_z_q <= dim_clamp;
				REG_DST_X:    dst_x_q <= dim_clamp;
				REG_DST_Y:    dst_y_q <= dim_clamp;
				REG_DST_Z:    dst_z_q <= dim_clamp;
				REG_CHANNELS: chan_q  <= chan_clamp;
				default: begin
				end
			endcase
		end
	end

	assign src_x      = src_x_q;
	assign src_y      = src_y_q;
	assign src_z      = src_z_q;
	assign dst_x      = dst_x_q;
	assign dst_y      = dst_y_q;
	assign dst_z      = dst_z_q;
	assign chan_count = chan_q;

endmodule

`default_nettype wire

@@ hw/rtl/ccpv_pos.sv @@
// ----------------------------------------------------------------------------
// ccpv_pos: source coordinate counters
// Counts the raster position of the next source voxel, x fastest, then y,
// z and channel, and wraps to zero after the last voxel of the volume.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpv_pos #(
	parameter int POS_W = 12,
	parameter int DIM_W = 13,
	parameter int PC_W  = 4,
	parameter int CHN_W = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             clear,
	input  wire logic             step,
	input  wire logic [DIM_W-1:0] src_x,
	input  wire logic [DIM_W-1:0] src_y,
	input  wire logic [DIM_W-1:0] src_z,
	input  wire logic [CHN_W-1:0] chan_count,
	output logic      [POS_W-1:0] pos_x,
	output logic      [POS_W-1:0] pos_y,
	output logic      [POS_W-1:0] pos_z,
	output logic      [PC_W-1:0]  pos_c
);
	logic [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [PC_W-1:0]  pos_c_q;
	logic             x_last, y_last, z_last, c_last;

	// End of row, plane, volume and channel set.
	always_comb begin
		x_last = (DIM_W'(pos_x_q) == src_x - DIM_W'(1));
		y_last = (DIM_W'(pos_y_q) == src_y - DIM_W'(1));
		z_last = (DIM_W'(pos_z_q) == src_z - DIM_W'(1));
		c_last = (CHN_W'(pos_c_q) == chan_count - CHN_W'(1));
	end

	// Any register write starts a new volume.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			pos_c_q <= '0;
		end else if (clear) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			pos_c_q <= '0;
		end else if (step) begin
			pos_x_q <= x_last ? '0 : pos_x_q + POS_W'(1);
			if (x_last) begin
				pos_y_q <= y_last ? '0 : pos_y_q + POS_W'(1);
				if (y_last) begin
					pos_z_q <= z_last ? '0 : pos_z_q + POS_W'(1);
					if (z_last) begin
						pos_c_q <= c_last ? '0 : pos_c_q + PC_W'(1);
					end
				end
			end
		end
	end

	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign pos_z = pos_z_q;
	assign pos_c = pos_c_q;

endmodule

`default_nettype wire

@@ hw/rtl/ccpv_axis.sv @@
// ----------------------------------------------------------------------------
// ccpv_axis: crop or pad mapping of one axis
// Takes the offset between the centers of source and destination, tests the
// crop window and gives the destination coordinate.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpv_axis #(
	parameter int POS_W = 12,
	parameter int DIM_W = 13
) (
	input  wire logic [POS_W-1:0] pos,
	input  wire logic [DIM_W-1:0] src,
	input  wire logic [DIM_W-1:0] dst,
	output logic                  keep,
	output logic      [POS_W-1:0] tpos
);
	logic [DIM_W-1:0] half_src, half_dst, off, pos_w;
	logic [DIM_W:0]   win_end;
	logic             crop;

	always_comb begin
		half_src = src >> 1;
		half_dst = dst >> 1;
		off      = (half_dst >= half_src) ? half_dst - half_src : half_src - half_dst;
		crop     = (dst <= src);
		pos_w    = DIM_W'(pos);
		win_end  = {1'b0, off} + {1'b0, dst};
		// A padded axis keeps every voxel; a cropped one only those in the window.
		keep     = !crop || ((pos_w >= off) && ({1'b0, pos_w} < win_end));
		tpos     = crop ? POS_W'(pos_w - off) : POS_W'(pos_w + off);
	end

endmodule

`default_nettype wire

@@ hw/rtl/ccpv_addr.sv @@
// ----------------------------------------------------------------------------
// ccpv_addr: destination address pipeline
// Three stages, one multiply and add each, build the linear address
// ((c * dst_z + z) * dst_y + y) * dst_x + x; the last stage is the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpv_addr #(
	parameter int POS_W       = 12,
	parameter int DIM_W       = 13,
	parameter int PC_W        = 4,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire logic [PC_W-1:0]             req_c,
	input  wire logic [POS_W-1:0]            req_x,
	input  wire logic [POS_W-1:0]            req_y,
	input  wire logic [POS_W-1:0]            req_z,
	input  wire logic [SAMPLE_BITS-1:0]      req_sample,
	input  wire logic [DIM_W-1:0]            dst_x,
	input  wire logic [DIM_W-1:0]            dst_y,
	input  wire logic [DIM_W-1:0]            dst_z,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [ccpv_pkg::ADDR_W-1:0]      dest_address,
	output logic [SAMPLE_BITS-1:0]           sample_out
);
	import ccpv_pkg::*;

	localparam int A_W    = PC_W + DIM_W;
	localparam int B_W    = A_W + DIM_W;
	localparam int C_W    = B_W + DIM_W;
	localparam int FULL_W = (C_W > ADDR_W) ? C_W : ADDR_W;

	logic                   valid_s3, valid_s4, valid_s5;
	logic                   ready_s3, ready_s4, ready_s5;
	logic [A_W-1:0]         a_s3;
	logic [B_W-1:0]         b_s4;
	logic [ADDR_W-1:0]      addr_s5;
	logic [POS_W-1:0]       x_s3, x_s4, y_s3;
	logic [SAMPLE_BITS-1:0] sample_s3, sample_s4, sample_s5;
	logic [FULL_W-1:0]      addr_full;

	// A stage loads when it is empty or its content moves on.
	assign ready_s5  = !valid_s5 || out_ready;
	assign ready_s4  = !valid_s4 || ready_s5;
	assign ready_s3  = !valid_s3 || ready_s4;
	assign req_ready = ready_s3;

	assign addr_full = FULL_W'(b_s4) * FULL_W'(dst_x) + FULL_W'(x_s4);

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s3) begin
				valid_s3 <= req_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
			if (ready_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// Plane index, then row index, then the full address.
	always_ff @(posedge clk) begin
		if (ready_s3 && req_valid) begin
			a_s3      <= A_W'(req_c) * A_W'(dst_z) + A_W'(req_z);
			x_s3      <= req_x;
			y_s3      <= req_y;
			sample_s3 <= req_sample;
		end
		if (ready_s4 && valid_s3) begin
			b_s4      <= B_W'(a_s3) * B_W'(dst_y) + B_W'(y_s3);
			x_s4      <= x_s3;
			sample_s4 <= sample_s3;
		end
		if (ready_s5 && valid_s4) begin
			addr_s5   <= addr_full[ADDR_W-1:0];
			sample_s5 <= sample_s4;
		end
	end

	assign out_valid    = valid_s5;
	assign dest_address = addr_s5;
	assign sample_out   = sample_s5;

endmodule

`default_nettype wire

@@ hw/rtl/center_crop_pad_volume.sv @@
// ----------------------------------------------------------------------------
// center_crop_pad_volume: center crop or pad of a 3-D multi-channel volume
// Source voxels stream in raster order; each voxel inside the crop window
// leaves with its linear address in the destination volume.
//
//   Channel   Signals                            Moves
//   input     in_valid, in_ready, sample_in      one source voxel
//   output    out_valid, out_ready,              one kept voxel and its
//             dest_address, sample_out           destination address
//   config    cfg_write, cfg_index, cfg_data     one register write
//
// One voxel is taken every cycle while in_ready is high; after the input
// register a kept voxel passes the axis mapping register and the three
// multiply-add stages of the address chain, the last of which is the output.
// Reset clears the valid bits and coordinate counters and sets every size
// register to one. A stalled output holds its stage; the stages before it keep
// filling until the pipeline is full, and only then does in_ready drop.
// ----------------------------------------------------------------------------
`default_nettype none

module center_crop_pad_volume #(
	parameter int MAX_DIM      = 4096,
	parameter int SAMPLE_BITS  = 16,
	parameter int MAX_CHANNELS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [SAMPLE_BITS-1:0]          sample_in,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [ccpv_pkg::ADDR_W-1:0]     dest_address,
	output logic      [SAMPLE_BITS-1:0]          sample_out,
	input  wire logic                            cfg_write,
	input  wire logic [ccpv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ccpv_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ccpv_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int POS_W = $clog2(MAX_DIM);
	localparam int CHN_W = $clog2(MAX_CHANNELS + 1);
	localparam int PC_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	logic [DIM_W-1:0]       src_x, src_y, src_z, dst_x, dst_y, dst_z;
	logic [CHN_W-1:0]       chan_count;
	logic [POS_W-1:0]       pos_x, pos_y, pos_z;
	logic [PC_W-1:0]        pos_c;
	logic                   in_accept;

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [POS_W-1:0]       x_s1, y_s1, z_s1;
	logic [PC_W-1:0]        c_s1;

	logic                   keep_x, keep_y, keep_z, keep_all;
	logic [POS_W-1:0]       tx, ty, tz;

	logic                   valid_s2, ready_s2, addr_ready;
	logic [SAMPLE_BITS-1:0] sample_s2;
	logic [POS_W-1:0]       tx_s2, ty_s2, tz_s2;
	logic [PC_W-1:0]        c_s2;

	assign ready_s2  = !valid_s2 || addr_ready;
	assign in_ready  = !valid_s1 || ready_s2;
	assign in_accept = in_valid && in_ready;

	// Configuration registers.
	ccpv_cfg #(
		.MAX_DIM     (MAX_DIM),
		.MAX_CHANNELS(MAX_CHANNELS),
		.DIM_W       (DIM_W),
		.CHN_W       (CHN_W)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_x     (src_x),
		.src_y     (src_y),
		.src_z     (src_z),
		.dst_x     (dst_x),
		.dst_y     (dst_y),
		.dst_z     (dst_z),
		.chan_count(chan_count)
	);

	// Source coordinate of the next voxel.
	ccpv_pos #(
		.POS_W(POS_W),
		.DIM_W(DIM_W),
		.PC_W (PC_W),
		.CHN_W(CHN_W)
	) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (cfg_write),
		.step      (in_accept),
		.src_x     (src_x),
		.src_y     (src_y),
		.src_z     (src_z),
		.chan_count(chan_count),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.pos_c     (pos_c)
	);

	// Input register: the voxel and its source coordinate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_s1 <= sample_in;
			x_s1      <= pos_x;
			y_s1      <= pos_y;
			z_s1      <= pos_z;
			c_s1      <= pos_c;
		end
	end

	// Per-axis window test and coordinate mapping.
	ccpv_axis #(.POS_W(POS_W), .DIM_W(DIM_W)) u_axis_x (
		.pos (x_s1),
		.src (src_x),
		.dst (dst_x),
		.keep(keep_x),
		.tpos(tx)
	);

	ccpv_axis #(.POS_W(POS_W), .DIM_W(DIM_W)) u_axis_y (
		.pos (y_s1),
		.src (src_y),
		.dst (dst_y),
		.keep(keep_y),
		.tpos(ty)
	);

	ccpv_axis #(.POS_W(POS_W), .DIM_W(DIM_W)) u_axis_z (
		.pos (z_s1),
		.src (src_z),
		.dst (dst_z),
		.keep(keep_z),
		.tpos(tz)
	);

	assign keep_all = keep_x && keep_y && keep_z;

	// Mapping register; a voxel outside the window is dropped here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1 && keep_all;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			sample_s2 <= sample_s1;
			tx_s2     <= tx;
			ty_s2     <= ty;
			tz_s2     <= tz;
			c_s2      <= c_s1;
		end
	end

	// Destination address and output register.
	ccpv_addr #(
		.POS_W      (POS_W),
		.DIM_W      (DIM_W),
		.PC_W       (PC_W),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_addr (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (valid_s2),
		.req_ready   (addr_ready),
		.req_c       (c_s2),
		.req_x       (tx_s2),
		.req_y       (ty_s2),
		.req_z       (tz_s2),
		.req_sample  (sample_s2),
		.dst_x       (dst_x),
		.dst_y       (dst_y),
		.dst_z       (dst_z),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.dest_address(dest_address),
		.sample_out  (sample_out)
	);

	// A register write always starts a new volume at the origin.
	a_cfg_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> (pos_x == '0 && pos_y == '0 && pos_z == '0 && pos_c == '0))
		else $error("coordinate counters not cleared by a register write");

	// A voxel that passed the window test lies inside the destination volume.
	a_mapped_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (DIM_W'(tx_s2) < dst_x && DIM_W'(ty_s2) < dst_y &&
			DIM_W'(tz_s2) < dst_z))
		else $error("mapped coordinate outside the destination volume");

	// The channel counter never reaches the channel count.
	a_chan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CHN_W'(pos_c) < chan_count)
		else $error("channel counter out of range");

endmodule

`default_nettype wire
